// ===== sv/two_channel_block_median_unit_assert.svh =====
// Assertion macros shared by the two-channel block median unit.
// Depends on nothing; a user module must provide clk and rst.
`ifndef TWO_CHANNEL_BLOCK_MEDIAN_UNIT_ASSERT_SVH
`define TWO_CHANNEL_BLOCK_MEDIAN_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCBM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcbm: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TCBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcbm: next-cycle check failed");

`endif

// ===== sv/tcbm_pkg.sv =====
// Package for the two-channel block median unit: beat types, controller
// states and the command and status bundles. Depends on nothing.
`timescale 1ns / 1ps

package tcbm_pkg;

  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned WINDOW_DEFAULT = 15;

  typedef struct packed {
    logic                   channel;
    logic [SAMPLE_BITS-1:0] distance;
  } sample_t;

  typedef struct packed {
    logic                   channel_out;
    logic [SAMPLE_BITS-1:0] median;
    logic                   median_valid;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MED_RD,
    ST_MED_CAP,
    ST_PRIME,
    ST_SCAN,
    ST_PLACE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RD_J,
    RD_J_MINUS1,
    RD_MID
  } rd_sel_t;

  typedef enum logic {
    WA_J,
    WA_J_PLUS1
  } wa_sel_t;

  typedef enum logic {
    WD_SAMPLE,
    WD_SHIFT
  } wd_sel_t;

  typedef struct packed {
    logic    load;
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    dec_j;
    logic    cap_med;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic gt;
    logic j_zero;
    logic out_free;
  } status_t;

endpackage

// ===== sv/tcbm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Depends on nothing.
`timescale 1ns / 1ps

module tcbm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tcbm_ctrl.sv =====
// Controller for the two-channel block median unit: sequences the sorted
// insertion and the median read. Depends on tcbm_pkg.
`timescale 1ns / 1ps

module tcbm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  tcbm_pkg::status_t status,
  output tcbm_pkg::cmd_t    cmd
);

  tcbm_pkg::state_t state;
  tcbm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcbm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_stall = 1'b1;
    cmd          = '0;
    cmd.rd_sel   = tcbm_pkg::RD_J;
    cmd.wa_sel   = tcbm_pkg::WA_J;
    cmd.wd_sel   = tcbm_pkg::WD_SAMPLE;
    case (state)
      tcbm_pkg::ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.load = 1'b1;
          if (status.full) begin
            state_next = tcbm_pkg::ST_MED_RD;
          end else if (status.empty) begin
            state_next = tcbm_pkg::ST_PLACE;
          end else begin
            state_next = tcbm_pkg::ST_PRIME;
          end
        end
      end
      tcbm_pkg::ST_MED_RD: begin
        // Read the middle entry and restart the store with the new sample.
        cmd.rd_sel = tcbm_pkg::RD_MID;
        cmd.wr_en  = 1'b1;
        state_next = tcbm_pkg::ST_MED_CAP;
      end
      tcbm_pkg::ST_MED_CAP: begin
        cmd.cap_med = 1'b1;
        state_next  = tcbm_pkg::ST_EMIT;
      end
      tcbm_pkg::ST_PRIME: begin
        cmd.rd_sel = tcbm_pkg::RD_J;
        state_next = tcbm_pkg::ST_SCAN;
      end
      tcbm_pkg::ST_SCAN: begin
        cmd.rd_sel = tcbm_pkg::RD_J_MINUS1;
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = tcbm_pkg::WA_J_PLUS1;
        if (status.gt) begin
          cmd.wd_sel = tcbm_pkg::WD_SHIFT;
          if (status.j_zero) begin
            state_next = tcbm_pkg::ST_PLACE;
          end else begin
            cmd.dec_j = 1'b1;
          end
        end else begin
          cmd.wd_sel = tcbm_pkg::WD_SAMPLE;
          state_next = tcbm_pkg::ST_EMIT;
        end
      end
      tcbm_pkg::ST_PLACE: begin
        cmd.wr_en  = 1'b1;
        state_next = tcbm_pkg::ST_EMIT;
      end
      tcbm_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = tcbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcbm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/tcbm_dp.sv =====
// Datapath for the two-channel block median unit: fill counters, sorted
// sample store, compare unit and result register. Depends on tcbm_pkg, tcbm_ram.
`timescale 1ns / 1ps

module tcbm_dp #(
  parameter int unsigned WINDOW = tcbm_pkg::WINDOW_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  tcbm_pkg::sample_t sample,
  input  tcbm_pkg::cmd_t    cmd,
  output tcbm_pkg::status_t status,
  output tcbm_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_stall
);

  localparam int unsigned IW    = $clog2(WINDOW);
  localparam int unsigned FW    = $clog2(WINDOW + 1);
  localparam int unsigned AW    = IW + 1;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned MID   = WINDOW / 2;
  localparam int unsigned SB    = tcbm_pkg::SAMPLE_BITS;

  logic [FW-1:0]     fill [2];
  logic [FW-1:0]     fill_in;
  logic [FW-1:0]     fill_m1;
  tcbm_pkg::sample_t cur;
  logic [IW-1:0]     j;
  logic [IW-1:0]     rd_idx;
  logic [IW-1:0]     wr_idx;
  logic [SB-1:0]     res_median;
  logic              res_valid;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [SB-1:0]     ram_wdata;
  logic [SB-1:0]     ram_rdata;

  assign fill_in = fill[sample.channel];
  assign fill_m1 = fill_in - FW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill[0] <= '0;
      fill[1] <= '0;
    end else if (cmd.load) begin
      if (status.full) begin
        fill[sample.channel] <= FW'(1);
      end else begin
        fill[sample.channel] <= fill_in + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur        <= sample;
      res_valid  <= status.full;
      res_median <= '0;
      if (status.full || status.empty) begin
        j <= '0;
      end else begin
        j <= fill_m1[IW-1:0];
      end
    end else begin
      if (cmd.dec_j) begin
        j <= j - IW'(1);
      end
      if (cmd.cap_med) begin
        res_median <= ram_rdata;
      end
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      tcbm_pkg::RD_J:        rd_idx = j;
      tcbm_pkg::RD_J_MINUS1: rd_idx = j - IW'(1);
      tcbm_pkg::RD_MID:      rd_idx = IW'(MID);
      default:               rd_idx = j;
    endcase
  end

  assign wr_idx    = (cmd.wa_sel == tcbm_pkg::WA_J) ? j : j + IW'(1);
  assign ram_we    = cmd.wr_en;
  assign ram_waddr = {cur.channel, wr_idx};
  assign ram_raddr = {cur.channel, rd_idx};
  assign ram_wdata = (cmd.wd_sel == tcbm_pkg::WD_SAMPLE) ? cur.distance : ram_rdata;

  tcbm_ram #(
    .WIDTH(SB),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.channel_out  <= cur.channel;
      result.median       <= res_median;
      result.median_valid <= res_valid;
    end
  end

  assign status.full     = (fill_in == FW'(WINDOW));
  assign status.empty    = (fill_in == '0);
  assign status.gt       = (ram_rdata > cur.distance);
  assign status.j_zero   = (j == '0);
  assign status.out_free = !result_valid || !result_stall;

endmodule

// ===== sv/two_channel_block_median_unit.sv =====
// Top level of the two-channel block median unit: joins controller and
// datapath. Depends on tcbm_pkg, tcbm_ctrl, tcbm_dp and the assertion header.
`timescale 1ns / 1ps
`include "two_channel_block_median_unit_assert.svh"

// Usage. Each sample beat carries a channel flag (left or right) and a distance.
// Every sample beat produces exactly one result beat, in order. While a
// channel's window is filling, the result carries median zero, not valid. When
// a sample arrives for a full window, the median of that window is returned as
// valid and the window restarts holding only the new sample.
// Each channel keeps its window already sorted: a new sample is inserted by one
// compare unit that walks the store in RAM from the top, one entry per cycle.
// An accepted beat is offered as a result after a median read, or after an
// insertion walk through the single RAM port pair. The block takes one
// sample at a time: it stalls its input until the result of the last one
// has been loaded into the output register.
// The result sits in an output register, so a new sample is accepted while a
// finished result is still stalled; the next result waits until it is taken.
// Reset clears both fill counters and the controller; the store itself needs
// no clearing, as read data is used only from entries that have been written.

module two_channel_block_median_unit #(
  parameter int unsigned WINDOW = tcbm_pkg::WINDOW_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  tcbm_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_stall,
  output tcbm_pkg::result_t result
);

  tcbm_pkg::cmd_t    cmd;
  tcbm_pkg::status_t status;

  // The controller owns the sequence; the datapath only follows commands.
  tcbm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .status      (status),
    .cmd         (cmd)
  );

  tcbm_dp #(
    .WINDOW(WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .cmd         (cmd),
    .status      (status),
    .result      (result),
    .result_valid(result_valid),
    .result_stall(result_stall)
  );

  // Once a beat is taken the block is busy with it.
  `TCBM_ASSERT_NEXT(a_busy_after_beat, sample_valid && !sample_stall, sample_stall)
  // A waiting result is never overwritten.
  `TCBM_ASSERT_IMP(a_no_overwrite, cmd.out_load, status.out_free)
  // A result without a median carries zero.
  `TCBM_ASSERT_IMP(a_zero_when_invalid, result_valid && !result.median_valid, result.median == '0)
  // The insertion walk never steps below the first entry.
  `TCBM_ASSERT_IMP(a_no_index_underflow, cmd.dec_j, !status.j_zero)

endmodule

// ===== tb/tb_two_channel_block_median_unit.sv =====
// Testbench for the two-channel block median unit: directed and random sample
// beats, an in-bench window predictor and an in-order result checker.
// Depends on tcbm_pkg and two_channel_block_median_unit.
`timescale 1ns / 1ps

module tb_two_channel_block_median_unit;

  localparam int unsigned WINDOW       = tcbm_pkg::WINDOW_DEFAULT;
  localparam int unsigned SAMPLE_BITS  = tcbm_pkg::SAMPLE_BITS;
  localparam int unsigned MID          = WINDOW / 2;
  localparam int unsigned NUM_RANDOM   = 2000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 4 * WINDOW + 8;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  typedef enum int unsigned {
    DIST_FULL,
    DIST_TIES,
    DIST_EXTREMES,
    DIST_BAND
  } dist_style_t;

  typedef enum int unsigned {
    LEAN_RANDOM,
    LEAN_LEFT,
    LEAN_RIGHT,
    LEAN_ALTERNATE
  } channel_lean_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  tcbm_pkg::sample_t sample       = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  tcbm_pkg::result_t result;

  // Predictor state: one store and one fill count per channel.
  logic [SAMPLE_BITS-1:0] window_store [2][WINDOW];
  int unsigned            window_fill [2];
  tcbm_pkg::result_t      pending_results [$];

  int unsigned err_count     = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_requests = 0;

  two_channel_block_median_unit #(
    .WINDOW(WINDOW)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // Appends one distance to its channel's store, or reduces a full store to
  // its median and restarts the store with the new distance.
  function automatic tcbm_pkg::result_t push_distance(input tcbm_pkg::sample_t beat);
    tcbm_pkg::result_t      outcome;
    logic [SAMPLE_BITS-1:0] ordered [WINDOW];
    logic [SAMPLE_BITS-1:0] key;
    logic                   ch;
    int                     i;
    int                     j;
    ch                   = beat.channel;
    outcome.channel_out  = beat.channel;
    outcome.median       = '0;
    outcome.median_valid = 1'b0;
    if (window_fill[ch] >= WINDOW) begin
      for (i = 0; i < WINDOW; i++) ordered[i] = window_store[ch][i];
      for (i = 1; i < WINDOW; i++) begin
        key = ordered[i];
        j   = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j + 1] = ordered[j];
          j--;
        end
        ordered[j + 1] = key;
      end
      outcome.median       = ordered[MID];
      outcome.median_valid = 1'b1;
      window_store[ch][0]  = beat.distance;
      window_fill[ch]      = 1;
    end else begin
      window_store[ch][window_fill[ch]] = beat.distance;
      window_fill[ch]                   = window_fill[ch] + 1;
    end
    return outcome;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_distance(input dist_style_t style,
                                                           input logic [SAMPLE_BITS-1:0] base);
    logic [SAMPLE_BITS-1:0] value;
    case (style)
      DIST_TIES: begin
        value = base + SAMPLE_BITS'($urandom_range(0, 2));
      end
      DIST_EXTREMES: begin
        case ($urandom_range(0, 3))
          0:       value = '0;
          1:       value = '1;
          2:       value = SAMPLE_BITS'(1);
          default: value = ~SAMPLE_BITS'(1);
        endcase
      end
      DIST_BAND: begin
        value = base + SAMPLE_BITS'($urandom_range(0, 63));
      end
      default: begin
        value = SAMPLE_BITS'($urandom);
      end
    endcase
    return value;
  endfunction

  // Offers one beat and holds it until it is taken; valid stays high so that
  // a following beat can go out on the very next cycle.
  task automatic send_sample(input logic ch, input logic [SAMPLE_BITS-1:0] dist_value);
    tcbm_pkg::sample_t beat;
    beat.channel  = ch;
    beat.distance = dist_value;
    sample_valid <= 1'b1;
    sample       <= beat;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    pending_results.push_back(push_distance(beat));
  endtask

  // Drops valid for a number of cycles, with junk on the idle payload.
  task automatic sender_gap(input int unsigned cycles);
    if (cycles == 0) return;
    sample_valid <= 1'b0;
    repeat (cycles) begin
      sample <= tcbm_pkg::sample_t'($urandom);
      @(posedge clk);
    end
  endtask

  // A left window with both extremes, repeated values and a repeat of the
  // minimum as its last entry, a few right beats in between, then the beat that
  // reduces the left window.
  task automatic test_directed_window();
    logic [SAMPLE_BITS-1:0] left_seq [WINDOW] = '{
      16'hFFFF, 16'hFFFF, 16'd40000, 16'd40000, 16'd40000,
      16'd20000, 16'd1, 16'd0, 16'd0, 16'd32768,
      16'hFFFE, 16'd12345, 16'd40000, 16'd7, 16'd0
    };
    logic [SAMPLE_BITS-1:0] right_seq [4] = '{16'hFFFF, 16'd0, 16'd500, 16'd500};
    int unsigned i;
    for (i = 0; i < WINDOW; i++) begin
      send_sample(CH_LEFT, left_seq[i]);
      if (i % 4 == 0) send_sample(CH_RIGHT, right_seq[i / 4]);
    end
    send_sample(CH_LEFT, 16'd100);
  endtask

  // Bursts of random length with random gaps; each burst picks how it uses
  // the channels and what kind of distances it sends.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned            sent;
    int unsigned            burst;
    int unsigned            k;
    int unsigned            pick;
    dist_style_t            style;
    channel_lean_t          lean;
    logic [SAMPLE_BITS-1:0] base;
    logic                   ch;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      pick  = $urandom_range(0, 7);
      style = (pick < 5) ? DIST_FULL : dist_style_t'(pick - 4);
      lean  = channel_lean_t'($urandom_range(0, 3));
      base  = SAMPLE_BITS'($urandom);
      for (k = 0; k < burst && sent < count; k++) begin
        case (lean)
          LEAN_LEFT:      ch = CH_LEFT;
          LEAN_RIGHT:     ch = CH_RIGHT;
          LEAN_ALTERNATE: ch = k[0];
          default:        ch = ($urandom_range(0, 1) == 1);
        endcase
        send_sample(ch, pick_distance(style, base));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 24));
    end
  endtask

  // The receiver holds off for a long stretch while beats keep being
  // offered back to back, so the block fills and stalls its input.
  task automatic test_output_hold();
    int unsigned k;
    hold_requests++;
    for (k = 0; k < 3 * WINDOW; k++) begin
      send_sample(($urandom_range(0, 1) == 1), pick_distance(DIST_FULL, '0));
    end
  endtask

  initial begin : result_stall_pattern
    stall_style_t style;
    int unsigned  span;
    int unsigned  phase;
    int unsigned  holds_done;
    phase      = 0;
    holds_done = 0;
    forever begin
      style = stall_style_t'($urandom_range(0, 3));
      span  = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk);
        phase++;
        if (hold_requests != holds_done) begin
          holds_done   = hold_requests;
          result_stall <= 1'b1;
          repeat (HOLD_CYCLES - 1) @(posedge clk);
        end else begin
          case (style)
            STALL_LIGHT:    result_stall <= ($urandom_range(0, 99) < 30);
            STALL_HEAVY:    result_stall <= ($urandom_range(0, 99) < 75);
            STALL_PERIODIC: result_stall <= (phase % 3 == 0);
            default:        result_stall <= 1'b0;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    tcbm_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: channel_out %0d median %0d median_valid %0d",
               result.channel_out, result.median, result.median_valid);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.channel_out !== want.channel_out) begin
          $error("channel_out: expected %0d, actual %0d", want.channel_out,
                 result.channel_out);
          err_count++;
        end
        if (result.median !== want.median) begin
          $error("median: expected %0d, actual %0d", want.median, result.median);
          err_count++;
        end
        if (result.median_valid !== want.median_valid) begin
          $error("median_valid: expected %0d, actual %0d", want.median_valid,
                 result.median_valid);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : run_limit
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_two_channel_block_median_unit: done, errors");
      $finish;
    end
  end

  initial begin : test_sequence
    window_fill[0] = 0;
    window_fill[1] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_window();
    test_random_traffic(NUM_RANDOM / 2);
    test_output_hold();
    test_random_traffic(NUM_RANDOM / 2);
    sender_gap(1);
    while (pending_results.size() != 0) @(posedge clk);
    // Any stray beat after the last expected one is caught by the checker.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_two_channel_block_median_unit: done, clean");
    end else begin
      $display("tb_two_channel_block_median_unit: done, errors");
    end
    $finish;
  end

endmodule
